>>> sv/ird_pkg.sv
// ----------------------------------------------------------------------------
// ird_pkg: shared types and constants for the indexed ring deque
// Command and status codes, controller states and fixed field widths.
// ----------------------------------------------------------------------------
package ird_pkg;

    localparam int CNT_W     = 7;    // counts, capacity, position
    localparam int DATA_W    = 32;   // data / read_data port width
    localparam int BC_W      = 3;    // byte_count width
    localparam int CMD_W     = 3;
    localparam int STAT_W    = 3;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 7;

    localparam int DEPTH_DEFAULT       = 64;
    localparam int ENTRY_BYTES_DEFAULT = 4;

    localparam logic [CNT_W-1:0] CAP_RESET = 7'd64;

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 1'b1;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_BACK  = 3'd0,
        CMD_PUSH_FRONT = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_READ_AT    = 3'd4,
        CMD_WRITE_AT   = 3'd5,
        CMD_REMOVE_AT  = 3'd6,
        CMD_CLEAR      = 3'd7
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK       = 3'd0,
        STAT_NOT_INIT = 3'd1,
        STAT_FULL     = 3'd2,
        STAT_EMPTY    = 3'd3,
        STAT_INVALID  = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ACCESS,
        ST_SHIFT
    } state_t;

endpackage

>>> sv/ird_slot_ram.sv
// ----------------------------------------------------------------------------
// ird_slot_ram: slot storage of the ring deque
// One write port and one read port, registered read data.
// ----------------------------------------------------------------------------
module ird_slot_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int EW    = 32
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [EW-1:0] wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [EW-1:0] rd_data
);

    logic [EW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> sv/indexed_ring_deque_unit.sv
// ----------------------------------------------------------------------------
// indexed_ring_deque_unit: double-ended queue over a ring of memory slots
// Push/pop at both ends, indexed read/overwrite/remove, clear. One result
// beat per command with status, read data and used/free counts.
// ----------------------------------------------------------------------------
//
//  channel   handshake              payload                          dir
//  --------  ---------------------  -------------------------------  ---
//  in        in_valid / in_ready    command data byte_count position  in
//  out       out_valid / out_ready  status read_data used_count       out
//                                   free_count
//  cfg       cfg_write (no stall)   cfg_index cfg_data                in
//
//  Flow: one command at a time. Every command has an accept step with
//  slot read issue, then a modify/write-back step into the result register.
//  remove_at adds a shift step per entry behind the removed one: the shift
//  loop does one memory read and one write per cycle on the single RAM.
//  Reset: pointers and counts clear, enable=0, capacity=64. Slot RAM is not
//  cleared; no held entry is ever read before it was written.
//  Stalls: the result register decouples out; a stalled result blocks only
//  the final write-back step, so the next command can still be accepted
//  once the current one has retired into the result register.
// ----------------------------------------------------------------------------
module indexed_ring_deque_unit
    import ird_pkg::*;
#(
    parameter int DEPTH       = DEPTH_DEFAULT,
    parameter int ENTRY_BYTES = ENTRY_BYTES_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,

    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [CMD_W-1:0]     command,
    input  logic [DATA_W-1:0]    data,
    input  logic [BC_W-1:0]      byte_count,
    input  logic [CNT_W-1:0]     position,

    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [STAT_W-1:0]    status,
    output logic [DATA_W-1:0]    read_data,
    output logic [CNT_W-1:0]     used_count,
    output logic [CNT_W-1:0]     free_count
);

    // slot address, stored byte lanes, ring-sum width, capacity ceiling
    localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LANES    = (ENTRY_BYTES < 4) ? ENTRY_BYTES : 4;
    localparam int EW       = 8 * LANES;
    localparam int SW       = ((AW > CNT_W) ? AW : CNT_W) + 1;
    localparam int CAP_MAX  = (DEPTH < 127) ? DEPTH : 127;
    localparam logic [CNT_W-1:0] CAP_MAX_C = CAP_MAX[CNT_W-1:0];

    // slot of offset k from base, ring of cap slots (base < cap, k <= cap)
    function automatic logic [AW-1:0] ring_slot(
        input logic [AW-1:0]    base,
        input logic [CNT_W-1:0] off,
        input logic [CNT_W-1:0] cap
    );
        logic [SW-1:0] s;
        logic [SW-1:0] c;
        s = SW'(base) + SW'(off);
        c = SW'(cap);
        if (s >= c)
        begin
            s = s - c;
        end
        return s[AW-1:0];
    endfunction

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    state_t              state_reg,       state_next;
    logic                enable_reg,      enable_next;
    logic [CNT_W-1:0]    cap_reg,         cap_next;
    logic [AW-1:0]       front_reg,       front_next;
    logic [CNT_W-1:0]    count_reg,       count_next;

    // command in flight
    cmd_t                op_cmd_reg,      op_cmd_next;
    status_t             op_stat_reg,     op_stat_next;
    logic [EW-1:0]       op_data_reg,     op_data_next;
    logic [EW-1:0]       op_mask_reg,     op_mask_next;
    logic [AW-1:0]       op_slot_reg,     op_slot_next;
    logic [AW-1:0]       rd_slot_reg,     rd_slot_next;
    logic [CNT_W-1:0]    shift_left_reg,  shift_left_next;

    // result register
    logic                out_valid_reg,   out_valid_next;
    status_t             status_reg,      status_next;
    logic [DATA_W-1:0]   read_data_reg,   read_data_next;
    logic [CNT_W-1:0]    used_reg,        used_next;
    logic [CNT_W-1:0]    free_reg,        free_next;

    // ------------------------------------------------------------------
    // RAM port
    // ------------------------------------------------------------------
    logic                mem_wr_en;
    logic [AW-1:0]       mem_wr_addr;
    logic [EW-1:0]       mem_wr_data;
    logic                mem_rd_en;
    logic [AW-1:0]       mem_rd_addr;
    logic [EW-1:0]       mem_q;

    ird_slot_ram #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .EW    (EW)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_q)
    );

    // ------------------------------------------------------------------
    // decode of the incoming beat
    // ------------------------------------------------------------------
    logic [CNT_W-1:0] eff_cap;
    logic             in_fire;
    logic             out_free;
    cmd_t             cmd_in;
    status_t          stat_in;
    logic             pos_ok;
    logic [EW-1:0]    mask_in;
    logic [AW-1:0]    slot_in;
    logic [AW-1:0]    prev_front;
    logic [AW-1:0]    pos_slot;
    logic             needs_read;

    // capacity 0 acts as 1, anything past the storage acts as the storage
    always_comb
    begin
        if (cap_reg == '0)
        begin
            eff_cap = CNT_W'(1);
        end
        else if (cap_reg > CAP_MAX_C)
        begin
            eff_cap = CAP_MAX_C;
        end
        else
        begin
            eff_cap = cap_reg;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign cmd_in   = cmd_t'(command);
    assign pos_ok   = (position != '0) && (position <= count_reg);

    // byte lanes written: min(byte_count, stored lanes)
    always_comb
    begin
        for (int b = 0; b < LANES; b++)
        begin
            mask_in[8*b +: 8] = (byte_count > b[BC_W-1:0]) ? 8'hFF : 8'h00;
        end
    end

    always_comb
    begin
        if (front_reg == '0)
        begin
            prev_front = AW'(SW'(eff_cap) - SW'(1));
        end
        else
        begin
            prev_front = front_reg - AW'(1);
        end
    end

    assign pos_slot = ring_slot(front_reg, position, eff_cap);

    // status is fully decided from the registers and the incoming beat at accept time
    always_comb
    begin
        stat_in = STAT_OK;
        if (!enable_reg)
        begin
            stat_in = STAT_NOT_INIT;
        end
        else
        begin
            case (cmd_in) inside
                CMD_PUSH_BACK, CMD_PUSH_FRONT:
                begin
                    if (count_reg >= eff_cap)
                    begin
                        stat_in = STAT_FULL;
                    end
                    else if (byte_count == '0)
                    begin
                        stat_in = STAT_INVALID;
                    end
                end
                CMD_POP_FRONT, CMD_POP_BACK:
                begin
                    if (count_reg == '0)
                    begin
                        stat_in = STAT_EMPTY;
                    end
                end
                CMD_READ_AT, CMD_WRITE_AT, CMD_REMOVE_AT:
                begin
                    if (count_reg == '0)
                    begin
                        stat_in = STAT_EMPTY;
                    end
                    else if (!pos_ok)
                    begin
                        stat_in = STAT_INVALID;
                    end
                end
                default:
                begin
                    stat_in = STAT_OK;
                end
            endcase
        end
    end

    // target slot of the command (for remove: destination of first move)
    always_comb
    begin
        case (cmd_in)
            CMD_PUSH_BACK:  slot_in = ring_slot(front_reg, count_reg, eff_cap);
            CMD_PUSH_FRONT: slot_in = prev_front;
            CMD_POP_BACK:   slot_in = ring_slot(front_reg, count_reg - CNT_W'(1), eff_cap);
            CMD_READ_AT, CMD_WRITE_AT, CMD_REMOVE_AT:
                            slot_in = ring_slot(front_reg, position - CNT_W'(1), eff_cap);
            default:        slot_in = front_reg;
        endcase
    end

    assign needs_read = (stat_in == STAT_OK) &&
                        (cmd_in inside {CMD_POP_FRONT, CMD_POP_BACK, CMD_READ_AT,
                                        CMD_WRITE_AT, CMD_REMOVE_AT});

    // ------------------------------------------------------------------
    // next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if ((stat_in == STAT_OK) && (cmd_in == CMD_REMOVE_AT) &&
                        (position < count_reg))
                    begin
                        state_next = ST_SHIFT;
                    end
                    else
                    begin
                        state_next = ST_ACCESS;
                    end
                end
            end
            ST_SHIFT:
            begin
                if (shift_left_reg == CNT_W'(1))
                begin
                    state_next = ST_ACCESS;
                end
            end
            ST_ACCESS:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // datapath, RAM control and result
    // ------------------------------------------------------------------
    always_comb
    begin
        enable_next     = enable_reg;
        cap_next        = cap_reg;
        front_next      = front_reg;
        count_next      = count_reg;
        op_cmd_next     = op_cmd_reg;
        op_stat_next    = op_stat_reg;
        op_data_next    = op_data_reg;
        op_mask_next    = op_mask_reg;
        op_slot_next    = op_slot_reg;
        rd_slot_next    = rd_slot_reg;
        shift_left_next = shift_left_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        status_next     = status_reg;
        read_data_next  = read_data_reg;
        used_next       = used_reg;
        free_next       = free_reg;
        mem_wr_en       = 1'b0;
        mem_wr_addr     = op_slot_reg;
        mem_wr_data     = op_data_reg;
        mem_rd_en       = 1'b0;
        mem_rd_addr     = slot_in;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    op_cmd_next     = cmd_in;
                    op_stat_next    = stat_in;
                    op_mask_next    = mask_in;
                    op_data_next    = data[EW-1:0] & mask_in;
                    op_slot_next    = slot_in;
                    rd_slot_next    = pos_slot;
                    shift_left_next = count_reg - position;
                    mem_rd_en       = needs_read;
                    // a remove fetches the entry behind the gap first
                    mem_rd_addr     = (cmd_in == CMD_REMOVE_AT) ? pos_slot : slot_in;
                end
            end
            ST_SHIFT:
            begin
                // move the entry fetched last cycle one place toward the front
                mem_wr_en       = 1'b1;
                mem_wr_addr     = op_slot_reg;
                mem_wr_data     = mem_q;
                op_slot_next    = ring_slot(op_slot_reg, CNT_W'(1), eff_cap);
                shift_left_next = shift_left_reg - CNT_W'(1);
                if (shift_left_reg != CNT_W'(1))
                begin
                    mem_rd_en    = 1'b1;
                    mem_rd_addr  = ring_slot(rd_slot_reg, CNT_W'(1), eff_cap);
                    rd_slot_next = mem_rd_addr;
                end
            end
            ST_ACCESS:
            begin
                if (out_free)
                begin
                    read_data_next = '0;
                    if (op_stat_reg == STAT_OK)
                    begin
                        case (op_cmd_reg)
                            CMD_PUSH_BACK:
                            begin
                                mem_wr_en  = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                            end
                            CMD_PUSH_FRONT:
                            begin
                                mem_wr_en  = 1'b1;
                                front_next = op_slot_reg;
                                count_next = count_reg + CNT_W'(1);
                            end
                            CMD_POP_FRONT:
                            begin
                                read_data_next = DATA_W'(mem_q);
                                front_next     = ring_slot(front_reg, CNT_W'(1), eff_cap);
                                count_next     = count_reg - CNT_W'(1);
                            end
                            CMD_POP_BACK:
                            begin
                                read_data_next = DATA_W'(mem_q);
                                count_next     = count_reg - CNT_W'(1);
                            end
                            CMD_READ_AT:
                            begin
                                read_data_next = DATA_W'(mem_q);
                            end
                            CMD_WRITE_AT:
                            begin
                                // upper lanes keep their old bytes
                                mem_wr_en   = 1'b1;
                                mem_wr_data = (mem_q & ~op_mask_reg) | op_data_reg;
                            end
                            CMD_REMOVE_AT:
                            begin
                                count_next = count_reg - CNT_W'(1);
                            end
                            default:
                            begin
                                front_next = '0;
                                count_next = '0;
                            end
                        endcase
                    end
                    out_valid_next = 1'b1;
                    status_next    = op_stat_reg;
                    if (op_stat_reg == STAT_NOT_INIT)
                    begin
                        used_next = '0;
                        free_next = '0;
                    end
                    else
                    begin
                        used_next = count_next;
                        free_next = eff_cap - count_next;
                    end
                end
            end
            default:
            begin
                mem_wr_en = 1'b0;
            end
        endcase

        // register writes; the user must issue them only while no command is in flight (not enforced here)
        if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_ENABLE:
                begin
                    enable_next = cfg_data[0];
                end
                CFG_CAPACITY:
                begin
                    cap_next   = cfg_data;
                    front_next = '0;
                    count_next = '0;
                end
                default:
                begin
                    enable_next = enable_reg;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // flops
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            enable_reg     <= 1'b0;
            cap_reg        <= CAP_RESET;
            front_reg      <= '0;
            count_reg      <= '0;
            shift_left_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            enable_reg     <= enable_next;
            cap_reg        <= cap_next;
            front_reg      <= front_next;
            count_reg      <= count_next;
            shift_left_reg <= shift_left_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_cmd_reg    <= op_cmd_next;
        op_stat_reg   <= op_stat_next;
        op_data_reg   <= op_data_next;
        op_mask_reg   <= op_mask_next;
        op_slot_reg   <= op_slot_next;
        rd_slot_reg   <= rd_slot_next;
        status_reg    <= status_next;
        read_data_reg <= read_data_next;
        used_reg      <= used_next;
        free_reg      <= free_next;
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign read_data  = read_data_reg;
    assign used_count = used_reg;
    assign free_count = free_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_count_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= eff_cap)
        else $error("entry count exceeds ring capacity");

    a_front_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
        SW'(front_reg) < SW'(eff_cap))
        else $error("front slot outside ring");

    a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_rd_en && mem_wr_en) |-> (mem_rd_addr != mem_wr_addr))
        else $error("read and write hit the same slot");

    a_shift_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SHIFT) |-> (shift_left_reg != '0))
        else $error("shift loop running with nothing left");

    a_error_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) && (status_reg != STAT_OK) |-> (read_data_reg == '0))
        else $error("error result carries data");

endmodule
